// File: rtl/npm_pkg.sv
package npm_pkg;

  // Storage and coordinate widths
  localparam int MAX_POINTS = 256;
  localparam int CW         = 32;                   // coordinate width
  localparam int AW         = $clog2(MAX_POINTS);   // store address width
  localparam int NW         = AW + 1;               // fill count width
  localparam int IW         = 8;                    // reported index width

  // Arithmetic widths
  localparam int DW   = CW + 1;          // coordinate difference
  localparam int SQW  = 2 * DW;          // product of two differences
  localparam int DSW  = SQW + 1;         // sum of two products
  localparam int MULW = DSW + DW;        // |dot| * |delta|
  localparam int NUMW = MULW + 2;        // rounded dividend
  localparam int DIVW = DSW + 1;         // divisor, twice the squared length
  localparam int QW   = 46;              // quotient bits kept
  localparam int SUMW = QW + 2;          // base plus offset
  localparam int MCW  = $clog2(DW);      // multiply step counter
  localparam int DCW  = $clog2(NUMW);    // divide step counter

  // Queue between front and back
  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_QUERY = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  // Back end sequencer states
  typedef enum logic [4:0] {
    S_IDLE, S_SCAN, S_SDRAIN, S_FETCH, S_FWAIT, S_NBL, S_NBR, S_NDRAIN,
    S_LA, S_LB, S_LWAIT, S_PREP, S_PROD, S_SUM, S_ABS, S_MUL, S_NUM,
    S_DIV, S_FIN, S_EMIT
  } state_t;

  typedef struct packed {
    req_t                 op;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
  } item_t;

  // A queue slot as seen by either neighbour
  typedef struct packed {
    logic  valid;
    item_t item;
  } slot_t;

endpackage

// File: rtl/npm_if.sv
interface npm_in_if import npm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           req_type;
  logic signed [CW-1:0] point_x;
  logic signed [CW-1:0] point_y;
  modport source (output valid, req_type, point_x, point_y, input ready);
  modport sink   (input valid, req_type, point_x, point_y, output ready);
endinterface

interface npm_out_if import npm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] match_x;
  logic signed [CW-1:0] match_y;
  logic [IW-1:0]        match_index;
  logic [1:0]           status;
  modport source (output valid, match_x, match_y, match_index, status, input ready);
  modport sink   (input valid, match_x, match_y, match_index, status, output ready);
endinterface

interface npm_cfg_if import npm_pkg::*; ();
  logic valid;
  logic ready;
  logic match_mode;
  modport source (output valid, match_mode, input ready);
  modport sink   (input valid, match_mode, output ready);
endinterface

// File: rtl/npm_front.sv
module npm_front import npm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  npm_in_if.sink    in_req,
  output slot_t     push,
  input  logic      push_ready
);

  logic  hold_vld_r;
  item_t hold_r;
  logic  take;

  // A request is taken whenever the holding stage is free or drains this cycle.
  assign in_req.ready = !hold_vld_r || push_ready;
  assign take         = in_req.valid && in_req.ready;

  // Unused request codes are taken and dropped here.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_vld_r <= 1'b0;
    end else if (take) begin
      hold_vld_r <= (req_t'(in_req.req_type) != REQ_NONE);
    end else if (push_ready) begin
      hold_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hold_r.op <= req_t'(in_req.req_type);
      hold_r.x  <= in_req.point_x;
      hold_r.y  <= in_req.point_y;
    end
  end

  assign push.valid = hold_vld_r;
  assign push.item  = hold_r;

endmodule

// File: rtl/npm_queue.sv
module npm_queue import npm_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  slot_t push,
  output logic  push_ready,
  output slot_t head,
  input  logic  pop
);

  item_t          mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r;
  logic [QAW-1:0] rd_ptr_r;
  logic [QCW-1:0] fill_r;
  logic           do_push;
  logic           do_pop;

  assign push_ready = (fill_r != QCW'(QDEPTH));
  assign do_push    = push.valid && push_ready;
  assign do_pop     = pop && (fill_r != '0);

  // Pointer and fill bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_r + QAW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_r + QAW'(1);
      end
      if (do_push && !do_pop) begin
        fill_r <= fill_r + QCW'(1);
      end else if (do_pop && !do_push) begin
        fill_r <= fill_r - QCW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.item;
    end
  end

  assign head.valid = (fill_r != '0);
  assign head.item  = mem_r[rd_ptr_r];

endmodule

// File: rtl/npm_back.sv
module npm_back import npm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      match_mode,
  input  slot_t     head,
  output logic      pop,
  npm_out_if.source out_res
);

  typedef enum logic [1:0] {RD_DIST, RD_NEAR, RD_A, RD_B} rd_kind_t;

  state_t state_r, state_nxt;

  // Reference store
  logic [CW-1:0] mem_x [MAX_POINTS];
  logic [CW-1:0] mem_y [MAX_POINTS];
  logic [NW-1:0] count_r;
  logic          wr_en;

  // Read port
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  rd_kind_t      rd_kind;
  logic          rd_valid_r;
  rd_kind_t      rd_kind_r;
  logic [AW-1:0] rd_idx_r;
  logic [CW-1:0] rd_x_r, rd_y_r;

  // Distance pipeline
  logic                  sd_valid_r, sq_valid_r;
  logic [AW-1:0]         sd_idx_r, sq_idx_r;
  logic signed [DW-1:0]  sdx_r, sdy_r;
  logic signed [SQW-1:0] sqx_r, sqy_r;
  logic [DSW-1:0]        sq_sum;
  logic [CW-1:0]         px, py;
  logic                  pipe_empty;

  // Query and search state
  logic [CW-1:0]  qx_r, qy_r;
  logic [NW-1:0]  scan_i_r;
  logic [DSW-1:0] best_r, dl_r, dr_r;
  logic [AW-1:0]  best_j_r;
  logic           nb_phase_r;
  logic [CW-1:0]  nx_r, ny_r;
  logic           has_l, has_r, use_r, line_mode;
  logic [AW-1:0]  ia;

  // Line projection
  logic [CW-1:0]         ax_r, ay_r, bx_r, by_r;
  logic signed [DW-1:0]  ddx_r, ddy_r, qdx_r, qdy_r;
  logic signed [SQW-1:0] p1_r, p2_r, p3_r, p4_r;
  logic [DSW-1:0]        len_r;
  logic signed [DSW-1:0] dot_r;
  logic [DSW-1:0]        mcand_r;
  logic [DW-1:0]         mplx_r, mply_r;
  logic                  negx_r, negy_r;
  logic [MULW-1:0]       accx_r, accy_r;
  logic [MCW-1:0]        mcnt_r;
  logic [NUMW-1:0]       numx_r, numy_r;
  logic [DIVW-1:0]       dvs_r, remx_r, remy_r;
  logic [DIVW:0]         rshx, rshy;
  logic                  geqx, geqy;
  logic [QW-1:0]         quox_r, quoy_r;
  logic [DCW-1:0]        dcnt_r;

  // Result staging and output register
  logic [CW-1:0] res_x_r, res_y_r;
  logic [AW-1:0] res_idx_r;
  status_t       res_st_r;
  logic          out_valid_r;
  logic [CW-1:0] out_x_r, out_y_r;
  logic [AW-1:0] out_idx_r;
  status_t       out_st_r;
  logic          out_load;

  // Base plus signed offset, clamped to the coordinate range.
  function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] base,
                                            input logic [QW-1:0] mag,
                                            input logic          neg);
    logic [SUMW-1:0] b;
    logic [SUMW-1:0] o;
    logic [SUMW-1:0] s;
    b = {{(SUMW-CW){base[CW-1]}}, base};
    o = {{(SUMW-QW){1'b0}}, mag};
    if (neg) begin
      o = -o;
    end
    s = b + o;
    if ((&s[SUMW-1:CW-1]) || !(|s[SUMW-1:CW-1])) begin
      sat_add = s[CW-1:0];
    end else if (s[SUMW-1]) begin
      sat_add = {1'b1, {(CW-1){1'b0}}};
    end else begin
      sat_add = {1'b0, {(CW-1){1'b1}}};
    end
  endfunction

  // Neighbour selection around the nearest point
  assign has_l     = (best_j_r != '0);
  assign has_r     = (({1'b0, best_j_r} + NW'(1)) < count_r);
  assign use_r     = (has_l && has_r) ? (dr_r < dl_r) : !has_l;
  assign ia        = use_r ? best_j_r : best_j_r - AW'(1);
  assign line_mode = match_mode && (count_r > NW'(1));

  assign pipe_empty = !rd_valid_r && !sd_valid_r && !sq_valid_r;
  assign px         = nb_phase_r ? nx_r : qx_r;
  assign py         = nb_phase_r ? ny_r : qy_r;
  assign sq_sum     = {1'b0, sqx_r} + {1'b0, sqy_r};
  assign out_load   = (state_r == S_EMIT) && (!out_valid_r || out_res.ready);

  assign rshx = {remx_r, numx_r[NUMW-1]};
  assign rshy = {remy_r, numy_r[NUMW-1]};
  assign geqx = (rshx >= {1'b0, dvs_r});
  assign geqy = (rshy >= {1'b0, dvs_r});

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (head.valid) begin
          case (head.item.op)
            REQ_LOAD:  if (count_r == NW'(MAX_POINTS)) state_nxt = S_EMIT;
            REQ_QUERY: state_nxt = (count_r == '0) ? S_EMIT : S_SCAN;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_SCAN:   if (scan_i_r == count_r - NW'(1)) state_nxt = S_SDRAIN;
      S_SDRAIN: if (pipe_empty) state_nxt = S_FETCH;
      S_FETCH:  state_nxt = S_FWAIT;
      S_FWAIT:  state_nxt = line_mode ? S_NBL : S_EMIT;
      S_NBL:    state_nxt = S_NBR;
      S_NBR:    state_nxt = S_NDRAIN;
      S_NDRAIN: if (pipe_empty) state_nxt = S_LA;
      S_LA:     state_nxt = S_LB;
      S_LB:     state_nxt = S_LWAIT;
      S_LWAIT:  state_nxt = S_PREP;
      S_PREP:   state_nxt = (ax_r == bx_r) ? S_EMIT : S_PROD;
      S_PROD:   state_nxt = S_SUM;
      S_SUM:    state_nxt = S_ABS;
      S_ABS:    state_nxt = S_MUL;
      S_MUL:    if (mcnt_r == MCW'(DW - 1)) state_nxt = S_NUM;
      S_NUM:    state_nxt = S_DIV;
      S_DIV:    if (dcnt_r == DCW'(NUMW - 1)) state_nxt = S_FIN;
      S_FIN:    state_nxt = S_EMIT;
      S_EMIT:   if (!out_valid_r || out_res.ready) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // State outputs: queue pop, store writes and store reads
  always_comb begin
    pop     = 1'b0;
    wr_en   = 1'b0;
    rd_en   = 1'b0;
    rd_addr = '0;
    rd_kind = RD_DIST;
    unique case (state_r)
      S_IDLE: begin
        pop   = head.valid;
        wr_en = head.valid && (head.item.op == REQ_LOAD) &&
                (count_r != NW'(MAX_POINTS));
      end
      S_SCAN: begin
        rd_en   = 1'b1;
        rd_addr = scan_i_r[AW-1:0];
      end
      S_FETCH: begin
        rd_en   = 1'b1;
        rd_addr = best_j_r;
        rd_kind = RD_NEAR;
      end
      S_NBL: begin
        rd_en   = has_l;
        rd_addr = best_j_r - AW'(1);
      end
      S_NBR: begin
        rd_en   = has_r;
        rd_addr = best_j_r + AW'(1);
      end
      S_LA: begin
        rd_en   = 1'b1;
        rd_addr = ia;
        rd_kind = RD_A;
      end
      S_LB: begin
        rd_en   = 1'b1;
        rd_addr = ia + AW'(1);
        rd_kind = RD_B;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rd_valid_r  <= 1'b0;
      sd_valid_r  <= 1'b0;
      sq_valid_r  <= 1'b0;
      nb_phase_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      rd_valid_r <= rd_en;
      sd_valid_r <= rd_valid_r && (rd_kind_r == RD_DIST);
      sq_valid_r <= sd_valid_r;
      if (wr_en) begin
        count_r <= count_r + NW'(1);
      end else if (pop && (head.item.op == REQ_CLEAR)) begin
        count_r <= '0;
      end
      if (state_r == S_IDLE) begin
        nb_phase_r <= 1'b0;
      end else if ((state_r == S_FWAIT) && line_mode) begin
        nb_phase_r <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Reference store with registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_x[count_r[AW-1:0]] <= head.item.x;
      mem_y[count_r[AW-1:0]] <= head.item.y;
    end
    if (rd_en) begin
      rd_x_r <= mem_x[rd_addr];
      rd_y_r <= mem_y[rd_addr];
    end
    rd_kind_r <= rd_kind;
    rd_idx_r  <= rd_addr;
  end

  // Datapath
  always_ff @(posedge clk) begin
    // Distance pipeline: difference, square, compare
    sd_idx_r <= rd_idx_r;
    sdx_r    <= {px[CW-1], px} - {rd_x_r[CW-1], rd_x_r};
    sdy_r    <= {py[CW-1], py} - {rd_y_r[CW-1], rd_y_r};
    sq_idx_r <= sd_idx_r;
    sqx_r    <= sdx_r * sdx_r;
    sqy_r    <= sdy_r * sdy_r;
    if (sq_valid_r) begin
      if (!nb_phase_r) begin
        if ((sq_idx_r == '0) || (sq_sum < best_r)) begin
          best_r   <= sq_sum;
          best_j_r <= sq_idx_r;
        end
      end else if (sq_idx_r == best_j_r + AW'(1)) begin
        dr_r <= sq_sum;
      end else begin
        dl_r <= sq_sum;
      end
    end

    // Points fetched for the line
    if (rd_valid_r) begin
      case (rd_kind_r)
        RD_NEAR: begin nx_r <= rd_x_r; ny_r <= rd_y_r; end
        RD_A:    begin ax_r <= rd_x_r; ay_r <= rd_y_r; end
        RD_B:    begin bx_r <= rd_x_r; by_r <= rd_y_r; end
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        scan_i_r  <= '0;
        qx_r      <= head.item.x;
        qy_r      <= head.item.y;
        res_x_r   <= '0;
        res_y_r   <= '0;
        res_idx_r <= '0;
        res_st_r  <= (head.item.op == REQ_LOAD) ? STAT_FULL : STAT_EMPTY;
      end
      S_SCAN: begin
        scan_i_r <= scan_i_r + NW'(1);
      end
      S_FWAIT: begin
        res_x_r   <= rd_x_r;
        res_y_r   <= rd_y_r;
        res_idx_r <= best_j_r;
        res_st_r  <= STAT_OK;
      end
      S_PREP: begin
        // A vertical line keeps its own x and the query's y.
        res_x_r <= ax_r;
        res_y_r <= qy_r;
        ddx_r   <= {bx_r[CW-1], bx_r} - {ax_r[CW-1], ax_r};
        ddy_r   <= {by_r[CW-1], by_r} - {ay_r[CW-1], ay_r};
        qdx_r   <= {qx_r[CW-1], qx_r} - {ax_r[CW-1], ax_r};
        qdy_r   <= {qy_r[CW-1], qy_r} - {ay_r[CW-1], ay_r};
      end
      S_PROD: begin
        p1_r <= ddx_r * ddx_r;
        p2_r <= ddy_r * ddy_r;
        p3_r <= qdx_r * ddx_r;
        p4_r <= qdy_r * ddy_r;
      end
      S_SUM: begin
        len_r <= {1'b0, p1_r} + {1'b0, p2_r};
        dot_r <= {p3_r[SQW-1], p3_r} + {p4_r[SQW-1], p4_r};
      end
      S_ABS: begin
        mcand_r <= dot_r[DSW-1] ? DSW'(-dot_r) : DSW'(dot_r);
        mplx_r  <= ddx_r[DW-1] ? DW'(-ddx_r) : DW'(ddx_r);
        mply_r  <= ddy_r[DW-1] ? DW'(-ddy_r) : DW'(ddy_r);
        negx_r  <= dot_r[DSW-1] ^ ddx_r[DW-1];
        negy_r  <= dot_r[DSW-1] ^ ddy_r[DW-1];
        accx_r  <= '0;
        accy_r  <= '0;
        mcnt_r  <= '0;
      end
      S_MUL: begin
        // Shift-and-add, multiplier bits from the top
        accx_r <= {accx_r[MULW-2:0], 1'b0} + (mplx_r[DW-1] ? MULW'(mcand_r) : '0);
        accy_r <= {accy_r[MULW-2:0], 1'b0} + (mply_r[DW-1] ? MULW'(mcand_r) : '0);
        mplx_r <= {mplx_r[DW-2:0], 1'b0};
        mply_r <= {mply_r[DW-2:0], 1'b0};
        mcnt_r <= mcnt_r + MCW'(1);
      end
      S_NUM: begin
        // Adding len before dividing by 2*len rounds half away from zero.
        numx_r <= NUMW'({accx_r, 1'b0}) + NUMW'(len_r);
        numy_r <= NUMW'({accy_r, 1'b0}) + NUMW'(len_r);
        dvs_r  <= {len_r, 1'b0};
        remx_r <= '0;
        remy_r <= '0;
        quox_r <= '0;
        quoy_r <= '0;
        dcnt_r <= '0;
      end
      S_DIV: begin
        // Restoring division, one quotient bit per cycle on each axis
        remx_r <= geqx ? DIVW'(rshx - {1'b0, dvs_r}) : DIVW'(rshx);
        remy_r <= geqy ? DIVW'(rshy - {1'b0, dvs_r}) : DIVW'(rshy);
        quox_r <= {quox_r[QW-2:0], geqx};
        quoy_r <= {quoy_r[QW-2:0], geqy};
        numx_r <= {numx_r[NUMW-2:0], 1'b0};
        numy_r <= {numy_r[NUMW-2:0], 1'b0};
        dcnt_r <= dcnt_r + DCW'(1);
      end
      S_FIN: begin
        res_x_r <= sat_add(ax_r, quox_r, negx_r);
        res_y_r <= sat_add(ay_r, quoy_r, negy_r);
      end
      default: ;
    endcase

    if (out_load) begin
      out_x_r   <= res_x_r;
      out_y_r   <= res_y_r;
      out_idx_r <= res_idx_r;
      out_st_r  <= res_st_r;
    end
  end

  assign out_res.valid       = out_valid_r;
  assign out_res.match_x     = out_x_r;
  assign out_res.match_y     = out_y_r;
  assign out_res.match_index = IW'(out_idx_r);
  assign out_res.status      = out_st_r;

  // The fill count never passes the store depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= NW'(MAX_POINTS))
    else $error("reference count exceeds capacity");

  // The scan only reads entries that hold points.
  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (scan_i_r < count_r))
    else $error("scan address beyond fill count");

  // Distance results only travel while a search phase is running.
  a_pipe_phase: assert property (@(posedge clk) disable iff (!rst_n)
    sq_valid_r |-> (state_r == S_SDRAIN || state_r == S_SCAN ||
                    state_r == S_NDRAIN || state_r == S_NBR))
    else $error("distance pipeline active outside a search");

  // A result is only staged once the previous one has been taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_res.ready) |=> (out_valid_r && $stable(out_x_r)))
    else $error("pending result overwritten");

endmodule

// File: rtl/nearest_point_line_matcher.sv
// Channel   Direction  Contents
// cfg_wr    in         match_mode (1 = project onto line to nearer neighbour)
// in_req    in         req_type, point_x, point_y (Q16.16)
// out_res   out        match_x, match_y, match_index, status
//
// A load or clear request passes the front holding register and the queue and is
// handled by the back end in its idle state. A query scans all N stored points through
// the single read port of the point store, one entry per cycle; in line mode a
// bit-serial multiply and a bit-serial divide follow the scan.
// Reset (rst_n, synchronous) empties the store; no clearing pass is needed.
// The front keeps taking requests into a two-entry queue while a query runs. A
// finished result waits in the output register; the back end only holds in its
// emit state when its next result is ready before the waiting one has been taken.
module nearest_point_line_matcher import npm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  npm_cfg_if.sink   cfg_wr,
  npm_in_if.sink    in_req,
  npm_out_if.source out_res
);

  logic  mode_r;
  slot_t push;
  logic  push_ready;
  slot_t head;
  logic  pop;

  // Mode register, always ready for a write
  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_wr.valid) begin
      mode_r <= cfg_wr.match_mode;
    end
  end

  npm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_req     (in_req),
    .push       (push),
    .push_ready (push_ready)
  );

  npm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ready (push_ready),
    .head       (head),
    .pop        (pop)
  );

  npm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .match_mode (mode_r),
    .head       (head),
    .pop        (pop),
    .out_res    (out_res)
  );

endmodule
